// File: hw/rtl/nmea_sentence_field_parser_top_defines.svh
// assertion macros used by the checker file nsfp_checker.sv
`ifndef NMEA_SENTENCE_FIELD_PARSER_TOP_DEFINES_SVH
`define NMEA_SENTENCE_FIELD_PARSER_TOP_DEFINES_SVH

// property checked on clk, masked while reset is asserted
`define NSFP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on clk at every edge, reset included
`define NSFP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/nsfp_pkg.sv
package nsfp_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_MIN_LEN_POS   = 3'd0;
	localparam logic [2:0] CFG_MIN_LEN_DEP   = 3'd1;
	localparam logic [2:0] CFG_BURST_LIM_POS = 3'd2;
	localparam logic [2:0] CFG_BURST_LIM_DEP = 3'd3;
	localparam logic [2:0] CFG_FIELD_LIM     = 3'd4;
	localparam logic [2:0] CFG_MARKER_LIM    = 3'd5;

	// register reset values
	localparam logic [9:0] RST_MIN_LEN_POS   = 10'd61;
	localparam logic [9:0] RST_MIN_LEN_DEP   = 10'd16;
	localparam logic [9:0] RST_BURST_LIM_POS = 10'd595;
	localparam logic [9:0] RST_BURST_LIM_DEP = 10'd50;
	localparam logic [4:0] RST_FIELD_LIM     = 5'd15;
	localparam logic [9:0] RST_MARKER_LIM    = 10'd100;

	// status codes
	localparam logic [1:0] ST_TOO_SHORT = 2'd0;
	localparam logic [1:0] ST_MISMATCH  = 2'd1;
	localparam logic [1:0] ST_NO_MARKER = 2'd2;
	localparam logic [1:0] ST_COMPLETE  = 2'd3;

	// sentence layout
	localparam logic [9:0] HDR_LEN    = 10'd7;
	localparam logic [3:0] POS_FIELDS = 4'd9;
	localparam logic [3:0] DEP_FIELDS = 4'd2;
	localparam logic [5:0] ERR_MAX    = 6'd63;

	// characters of interest
	localparam logic [7:0] CHR_COMMA = 8'h2C;
	localparam logic [7:0] CHR_STAR  = 8'h2A;
	localparam logic [7:0] CHR_DOT   = 8'h2E;
	localparam logic [7:0] CHR_0     = 8'h30;
	localparam logic [7:0] CHR_9     = 8'h39;
	localparam logic [7:0] CHR_A     = 8'h41;
	localparam logic [7:0] CHR_Z     = 8'h5A;

	typedef struct packed {
		logic [9:0] min_len_pos;
		logic [9:0] min_len_dep;
		logic [9:0] burst_lim_pos;
		logic [9:0] burst_lim_dep;
		logic [4:0] field_lim;
		logic [9:0] marker_lim;
	} nsfp_cfg_t;

	typedef struct packed {
		logic [9:0] pos;
		logic       header_ok;
		logic [3:0] cur_field;
		logic [4:0] char_cnt;
		logic [5:0] err;
		logic       marker;
		logic       kind;
	} nsfp_state_t;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] char_value;
		logic [3:0] field_number;
		logic       field_closed;
		logic       status_valid;
		logic [1:0] status_code;
		logic [5:0] overflow_errors;
		logic [9:0] burst_length;
	} nsfp_result_t;

	// expected header text, kind 0 "$GPRMC," and kind 1 "$SDDPT,"
	function automatic logic [7:0] header_char(input logic kind, input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0:    c = 8'h24;
			3'd1:    c = kind ? 8'h53 : 8'h47;
			3'd2:    c = kind ? 8'h44 : 8'h50;
			3'd3:    c = kind ? 8'h44 : 8'h52;
			3'd4:    c = kind ? 8'h50 : 8'h4D;
			3'd5:    c = kind ? 8'h54 : 8'h43;
			3'd6:    c = CHR_COMMA;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/nsfp_step.sv
module nsfp_step (
	input  nsfp_pkg::nsfp_cfg_t    cfg,
	input  nsfp_pkg::nsfp_state_t  st,
	input  logic                   mode,
	input  logic [7:0]             data_byte,
	input  logic                   burst_first,
	input  logic                   burst_last,
	output nsfp_pkg::nsfp_state_t  nx,
	output nsfp_pkg::nsfp_result_t res
);
	import nsfp_pkg::*;

	nsfp_state_t base;
	logic [9:0]  limit;
	logic [9:0]  min_len;
	logic        take;
	logic        in_hdr;
	logic [3:0]  nfields;
	logic        is_char;
	logic        is_term;
	logic [5:0]  cnt_inc;
	logic        cut;

	// byte classes
	assign is_char = ((data_byte >= CHR_0) && (data_byte <= CHR_9)) || (data_byte == CHR_DOT)
		|| ((data_byte >= CHR_A) && (data_byte <= CHR_Z));
	assign is_term = (data_byte == CHR_COMMA) || (data_byte == CHR_STAR);

	// per-burst state seen by this byte
	always_comb begin
		base = st;
		if (burst_first) begin
			base.pos       = '0;
			base.header_ok = 1'b1;
			base.cur_field = '0;
			base.char_cnt  = '0;
			base.err       = '0;
			base.marker    = 1'b0;
			base.kind      = mode;
		end
	end

	assign limit   = base.kind ? cfg.burst_lim_dep : cfg.burst_lim_pos;
	assign min_len = base.kind ? cfg.min_len_dep : cfg.min_len_pos;
	assign nfields = base.kind ? DEP_FIELDS : POS_FIELDS;
	assign take    = base.pos < limit;
	assign in_hdr  = base.pos < HDR_LEN;
	assign cnt_inc = {1'b0, base.char_cnt} + 6'd1;
	assign cut     = cnt_inc > {1'b0, cfg.field_lim};

	// byte handling, then status on the last byte of a burst
	always_comb begin
		nx  = base;
		res = '0;
		if (take) begin
			nx.pos = base.pos + 10'd1;
			if (in_hdr) begin
				if (data_byte != header_char(base.kind, base.pos[2:0])) begin
					nx.header_ok = 1'b0;
				end
			end else if (base.header_ok) begin
				if (base.cur_field < nfields) begin
					if (is_char || is_term) begin
						res.char_valid   = is_char;
						res.char_value   = is_char ? data_byte : 8'd0;
						res.field_number = base.cur_field;
						if (cut && (base.err != ERR_MAX)) begin
							nx.err = base.err + 6'd1;
						end
						if (is_term || cut) begin
							res.field_closed = 1'b1;
							nx.cur_field     = base.cur_field + 4'd1;
							nx.char_cnt      = '0;
						end else begin
							nx.char_cnt = cnt_inc[4:0];
						end
					end
				end else if (!base.kind && (base.pos < cfg.marker_lim)
						&& (data_byte == CHR_STAR)) begin
					nx.marker = 1'b1;
				end
			end
		end
		if (burst_last) begin
			res.status_valid    = 1'b1;
			res.overflow_errors = nx.err;
			res.burst_length    = nx.pos;
			priority if (nx.pos < min_len) begin
				res.status_code = ST_TOO_SHORT;
			end else if (!nx.header_ok || (nx.pos < HDR_LEN)) begin
				res.status_code = ST_MISMATCH;
			end else if (nx.kind || nx.marker) begin
				res.status_code = ST_COMPLETE;
			end else begin
				res.status_code = ST_NO_MARKER;
			end
			nx.pos       = '0;
			nx.header_ok = 1'b1;
			nx.cur_field = '0;
			nx.char_cnt  = '0;
			nx.err       = '0;
			nx.marker    = 1'b0;
		end
	end

endmodule

// File: hw/rtl/nmea_sentence_field_parser_top.sv
// channel   direction  handshake           contents
// in        input      in_valid/in_ready   mode, data_byte, burst_first, burst_last
// out       output     out_valid/out_ready one result per byte: char, field, status
// cfg       input      cfg_wr_en           cfg_index selects register, cfg_data value
//
// one byte per cycle while in_ready is high; each result is registered and appears in the cycle after its byte is taken
// the per-byte decode sits between the burst state and the output register
// in_ready drops only while the output register holds a result not yet taken
// reset loads register defaults and clears burst state; no clearing pass
module nmea_sentence_field_parser_top (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       burst_first,
	input  logic       burst_last,
	// output channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       char_valid,
	output logic [7:0] char_value,
	output logic [3:0] field_number,
	output logic       field_closed,
	output logic       status_valid,
	output logic [1:0] status_code,
	output logic [5:0] overflow_errors,
	output logic [9:0] burst_length,
	// configuration
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data
);
	import nsfp_pkg::*;

	nsfp_cfg_t    cfg_q;
	nsfp_state_t  state_q;
	nsfp_state_t  state_nx;
	nsfp_result_t res_nx;
	nsfp_result_t res_q;
	logic         out_valid_q;
	logic         in_fire;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_len_pos   <= RST_MIN_LEN_POS;
			cfg_q.min_len_dep   <= RST_MIN_LEN_DEP;
			cfg_q.burst_lim_pos <= RST_BURST_LIM_POS;
			cfg_q.burst_lim_dep <= RST_BURST_LIM_DEP;
			cfg_q.field_lim     <= RST_FIELD_LIM;
			cfg_q.marker_lim    <= RST_MARKER_LIM;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MIN_LEN_POS:   cfg_q.min_len_pos   <= cfg_data;
				CFG_MIN_LEN_DEP:   cfg_q.min_len_dep   <= cfg_data;
				CFG_BURST_LIM_POS: cfg_q.burst_lim_pos <= cfg_data;
				CFG_BURST_LIM_DEP: cfg_q.burst_lim_dep <= cfg_data;
				CFG_FIELD_LIM:     cfg_q.field_lim     <= cfg_data[4:0];
				CFG_MARKER_LIM:    cfg_q.marker_lim    <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-byte decode
	nsfp_step u_step (
		.cfg        (cfg_q),
		.st         (state_q),
		.mode       (mode),
		.data_byte  (data_byte),
		.burst_first(burst_first),
		.burst_last (burst_last),
		.nx         (state_nx),
		.res        (res_nx)
	);

	// burst state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pos       <= '0;
			state_q.header_ok <= 1'b1;
			state_q.cur_field <= '0;
			state_q.char_cnt  <= '0;
			state_q.err       <= '0;
			state_q.marker    <= 1'b0;
			state_q.kind      <= 1'b0;
			out_valid_q       <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q     <= state_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign char_valid      = res_q.char_valid;
	assign char_value      = res_q.char_value;
	assign field_number    = res_q.field_number;
	assign field_closed    = res_q.field_closed;
	assign status_valid    = res_q.status_valid;
	assign status_code     = res_q.status_code;
	assign overflow_errors = res_q.overflow_errors;
	assign burst_length    = res_q.burst_length;

endmodule

// File: hw/rtl/nsfp_checker.sv
`include "nmea_sentence_field_parser_top_defines.svh"

module nsfp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       char_valid,
	input logic [7:0] char_value,
	input logic [3:0] field_number,
	input logic       field_closed,
	input logic       status_valid,
	input logic [1:0] status_code,
	input logic [5:0] overflow_errors,
	input logic [9:0] burst_length
);

	logic        in_fire;
	logic        out_stall;
	logic [32:0] out_payload;
	logic [17:0] status_fields;

	// handshake and payload views
	assign in_fire       = in_valid && in_ready;
	assign out_stall     = out_valid && !out_ready;
	assign out_payload   = {char_valid, char_value, field_number, field_closed,
		status_valid, status_code, overflow_errors, burst_length};
	assign status_fields = {status_code, overflow_errors, burst_length};

	// no result shown in the cycle after a reset edge
	`NSFP_ASSERT_ALWAYS(a_rst_idle, !arst_n |=> !out_valid, "result valid after reset edge")

	// a stalled result holds its payload
	`NSFP_ASSERT(a_hold, out_stall |=> out_valid && $stable(out_payload), "stalled result changed")

	// every accepted byte gives a result in the next cycle
	`NSFP_ASSERT(a_one_result, in_fire |=> out_valid, "accepted byte gave no result")

	// no result without an accepted byte or a held one
	`NSFP_ASSERT(a_no_extra, !in_fire && !out_stall |=> !out_valid, "result without a transaction")

	// status fields stay zero away from a burst end
	`NSFP_ASSERT(a_status_zero, out_valid && !status_valid |-> status_fields == '0, "status set early")

endmodule

bind nmea_sentence_field_parser_top nsfp_checker u_nsfp_checker (.*);

// File: test/nsfp_result_checker.sv
`timescale 1ns / 1ps

module nsfp_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic       burst_first,
	input  logic       burst_last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       char_valid,
	input  logic [7:0] char_value,
	input  logic [3:0] field_number,
	input  logic       field_closed,
	input  logic       status_valid,
	input  logic [1:0] status_code,
	input  logic [5:0] overflow_errors,
	input  logic [9:0] burst_length,
	input  logic       cfg_wr_en,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	output int         fail_count,
	output int         pending
);
	import nsfp_pkg::*;

	localparam logic [55:0] POS_HEADER = "$GPRMC,";
	localparam logic [55:0] DEP_HEADER = "$SDDPT,";
	localparam int SHOW_LIMIT = 10;

	nsfp_cfg_t    reg_copy;
	nsfp_state_t  parse_st;
	nsfp_result_t expected_results[$];
	nsfp_result_t got_result;
	nsfp_result_t want_result;
	int           fails;

	// expected header character at a given position for a given port
	function automatic logic [7:0] header_byte(input logic kind, input logic [9:0] idx);
		logic [55:0] text;
		text = kind ? DEP_HEADER : POS_HEADER;
		return text[8 * (6 - idx) +: 8];
	endfunction

	function automatic string result_text(input nsfp_result_t r);
		return $sformatf("char %0b/%02h field %0d closed %0b status %0b/%0d err %0d len %0d",
			r.char_valid, r.char_value, r.field_number, r.field_closed,
			r.status_valid, r.status_code, r.overflow_errors, r.burst_length);
	endfunction

	task automatic clear_burst_state();
		parse_st.pos       = '0;
		parse_st.header_ok = 1'b1;
		parse_st.cur_field = '0;
		parse_st.char_cnt  = '0;
		parse_st.err       = '0;
		parse_st.marker    = 1'b0;
	endtask

	// advance the sentence parser by one byte and work out its result
	task automatic decode_byte(input logic m, input logic [7:0] ch, input logic first,
			input logic last, output nsfp_result_t res);
		logic [9:0] lim;
		logic [9:0] p;
		logic [9:0] min_len;
		logic [3:0] nfields;
		logic [5:0] cnt;
		logic       is_char;
		logic       is_term;
		logic       cut;
		res = '0;
		if (first) begin
			clear_burst_state();
			parse_st.kind = m;
		end
		lim = parse_st.kind ? reg_copy.burst_lim_dep : reg_copy.burst_lim_pos;
		if (parse_st.pos < lim) begin
			p = parse_st.pos;
			parse_st.pos = p + 10'd1;
			if (p < HDR_LEN) begin
				if (ch != header_byte(parse_st.kind, p))
					parse_st.header_ok = 1'b0;
			end else if (parse_st.header_ok) begin
				nfields = parse_st.kind ? DEP_FIELDS : POS_FIELDS;
				if (parse_st.cur_field < nfields) begin
					is_char = (ch >= CHR_0 && ch <= CHR_9) || ch == CHR_DOT ||
						(ch >= CHR_A && ch <= CHR_Z);
					is_term = ch == CHR_COMMA || ch == CHR_STAR;
					if (is_char || is_term) begin
						cnt = {1'b0, parse_st.char_cnt} + 6'd1;
						cut = cnt > {1'b0, reg_copy.field_lim};
						if (is_char) begin
							res.char_valid = 1'b1;
							res.char_value = ch;
						end
						res.field_number = parse_st.cur_field;
						if (cut && parse_st.err < ERR_MAX)
							parse_st.err = parse_st.err + 6'd1;
						if (is_term || cut) begin
							res.field_closed = 1'b1;
							parse_st.cur_field = parse_st.cur_field + 4'd1;
							parse_st.char_cnt = '0;
						end else begin
							parse_st.char_cnt = cnt[4:0];
						end
					end
				end else if (!parse_st.kind && p < reg_copy.marker_lim && ch == CHR_STAR) begin
					parse_st.marker = 1'b1;
				end
			end
		end
		// status on the closing byte of a burst
		if (last) begin
			min_len = parse_st.kind ? reg_copy.min_len_dep : reg_copy.min_len_pos;
			res.status_valid = 1'b1;
			if (parse_st.pos < min_len)
				res.status_code = ST_TOO_SHORT;
			else if (!parse_st.header_ok || parse_st.pos < HDR_LEN)
				res.status_code = ST_MISMATCH;
			else if (parse_st.kind || parse_st.marker)
				res.status_code = ST_COMPLETE;
			else
				res.status_code = ST_NO_MARKER;
			res.overflow_errors = parse_st.err;
			res.burst_length = parse_st.pos;
			clear_burst_state();
		end
	endtask

	task automatic note_failure(input string msg);
		fails++;
		if (fails <= SHOW_LIMIT)
			$display("[%0t] %s", $time, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_copy.min_len_pos   = RST_MIN_LEN_POS;
			reg_copy.min_len_dep   = RST_MIN_LEN_DEP;
			reg_copy.burst_lim_pos = RST_BURST_LIM_POS;
			reg_copy.burst_lim_dep = RST_BURST_LIM_DEP;
			reg_copy.field_lim     = RST_FIELD_LIM;
			reg_copy.marker_lim    = RST_MARKER_LIM;
			clear_burst_state();
			parse_st.kind = 1'b0;
			expected_results.delete();
			fails = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			// result transaction against the oldest prediction
			if (out_valid && out_ready) begin
				got_result = {char_valid, char_value, field_number, field_closed,
					status_valid, status_code, overflow_errors, burst_length};
				if (expected_results.size() == 0) begin
					note_failure({"unexpected result: ", result_text(got_result)});
				end else begin
					want_result = expected_results.pop_front();
					if (got_result !== want_result)
						note_failure({"mismatch: expected ", result_text(want_result),
							" got ", result_text(got_result)});
				end
			end
			// byte transaction feeds the predictor
			if (in_valid && in_ready) begin
				decode_byte(mode, data_byte, burst_first, burst_last, want_result);
				expected_results.push_back(want_result);
			end
			// register writes take effect after this edge
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_MIN_LEN_POS:   reg_copy.min_len_pos = cfg_data;
					CFG_MIN_LEN_DEP:   reg_copy.min_len_dep = cfg_data;
					CFG_BURST_LIM_POS: reg_copy.burst_lim_pos = cfg_data;
					CFG_BURST_LIM_DEP: reg_copy.burst_lim_dep = cfg_data;
					CFG_FIELD_LIM:     reg_copy.field_lim = cfg_data[4:0];
					CFG_MARKER_LIM:    reg_copy.marker_lim = cfg_data;
					default: ;
				endcase
			end
			fail_count <= fails;
			pending <= expected_results.size();
		end
	end

endmodule

// File: test/tb_nmea_sentence_field_parser_top.sv
`timescale 1ns / 1ps

module tb_nmea_sentence_field_parser_top;
	import nsfp_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int BYTES_PER_SETTING = 25;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       mode = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       burst_first = 1'b0;
	logic       burst_last = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       char_valid;
	logic [7:0] char_value;
	logic [3:0] field_number;
	logic       field_closed;
	logic       status_valid;
	logic [1:0] status_code;
	logic [5:0] overflow_errors;
	logic [9:0] burst_length;
	logic       cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;
	int         fail_count;
	int         pending;

	logic [7:0] sentence[$];
	int         send_idle_pct;
	int         recv_idle_pct = 0;
	int         cur_field_lim;
	int         bytes_sent;
	int         bursts_sent;
	int         setting_bytes;
	int         settings_done;
	int         stall_cycles = 0;

	nmea_sentence_field_parser_top u_dut (.*);

	nsfp_result_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side back-pressure
	always @(posedge clk)
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	function automatic logic [7:0] field_char();
		int unsigned k;
		k = $urandom_range(36);
		if (k < 10)
			return CHR_0 + 8'(k);
		else if (k == 10)
			return CHR_DOT;
		else
			return CHR_A + 8'(k - 11);
	endfunction

	function automatic logic [7:0] other_char();
		if ($urandom_range(1))
			return 8'h61 + 8'($urandom_range(25));
		else
			return 8'($urandom_range(255));
	endfunction

	task automatic load_text(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			sentence.push_back(s[k]);
	endtask

	// one byte transaction, with a random idle gap before it
	task automatic send_byte(input logic m, input logic [7:0] ch, input logic first,
			input logic last);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		data_byte <= ch;
		burst_first <= first;
		burst_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
		setting_bytes++;
	endtask

	// mode on bytes after the first is noise the block must ignore
	task automatic send_burst(input logic m, input logic with_first);
		int k;
		for (k = 0; k < sentence.size(); k++)
			send_byte((k == 0) ? m : 1'($urandom_range(1)), sentence[k],
				with_first && k == 0, k == sentence.size() - 1);
		bursts_sent++;
	endtask

	// header, fields with random content, then for position sentences a checksum tail in most cases
	task automatic build_sentence(input logic m);
		int nfields;
		int len;
		int k;
		int j;
		sentence.delete();
		if (m ^ ($urandom_range(15) == 0))
			load_text("$SDDPT,");
		else
			load_text("$GPRMC,");
		if ($urandom_range(11) == 0)
			sentence[$urandom_range(6)] = 8'($urandom_range(255));
		nfields = (m ? 2 : 9) + $urandom_range(1);
		for (k = 0; k < nfields; k++) begin
			len = ($urandom_range(7) == 0) ? $urandom_range(cur_field_lim + 2) : $urandom_range(3);
			for (j = 0; j < len; j++)
				sentence.push_back(($urandom_range(19) == 0) ? other_char() : field_char());
			sentence.push_back(($urandom_range(9) == 0) ? CHR_STAR : CHR_COMMA);
		end
		if (!m) begin
			len = $urandom_range(3);
			for (j = 0; j < len; j++)
				sentence.push_back(field_char());
			if ($urandom_range(4) != 0) begin
				sentence.push_back(CHR_STAR);
				sentence.push_back(field_char());
				sentence.push_back(field_char());
			end
		end
		if ($urandom_range(1)) begin
			sentence.push_back(8'h0D);
			sentence.push_back(8'h0A);
		end
	endtask

	// mostly well-formed sentences, some cut short, unmarked or pure noise
	task automatic random_burst();
		logic m;
		int r;
		int k;
		m = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 93) begin
			build_sentence(m);
			if (r >= 75 && r < 85) begin
				k = $urandom_range(1, sentence.size());
				while (sentence.size() > k)
					sentence.delete(sentence.size() - 1);
			end
		end else begin
			sentence.delete();
			k = $urandom_range(1, 12);
			repeat (k) sentence.push_back(8'($urandom_range(255)));
		end
		send_burst(m, !(r >= 85 && r < 93));
	endtask

	// drop valid and let every outstanding result drain
	task automatic settle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input nsfp_cfg_t c);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_MIN_LEN_POS;
		cfg_data <= c.min_len_pos;
		@(posedge clk);
		cfg_index <= CFG_MIN_LEN_DEP;
		cfg_data <= c.min_len_dep;
		@(posedge clk);
		cfg_index <= CFG_BURST_LIM_POS;
		cfg_data <= c.burst_lim_pos;
		@(posedge clk);
		cfg_index <= CFG_BURST_LIM_DEP;
		cfg_data <= c.burst_lim_dep;
		@(posedge clk);
		cfg_index <= CFG_FIELD_LIM;
		cfg_data <= {5'd0, c.field_lim};
		@(posedge clk);
		cfg_index <= CFG_MARKER_LIM;
		cfg_data <= c.marker_lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_field_lim = c.field_lim;
		settings_done++;
	endtask

	function automatic nsfp_cfg_t pick_setting(input int idx);
		nsfp_cfg_t c;
		case (idx)
			0: c = {RST_MIN_LEN_POS, RST_MIN_LEN_DEP, RST_BURST_LIM_POS, RST_BURST_LIM_DEP,
				RST_FIELD_LIM, RST_MARKER_LIM};
			1: c = {10'd0, 10'd0, 10'd1023, 10'd1023, 5'd31, 10'd1023};
			2: c = {10'd1023, 10'd1023, 10'd1, 10'd1, 5'd1, 10'd1};
			3: c = {10'd24, 10'd12, 10'd30, 10'd14, 5'd2, 10'd28};
			4: c = {10'($urandom_range(40)), 10'($urandom_range(20)),
				10'($urandom_range(20, 200)), 10'($urandom_range(8, 60)),
				5'($urandom_range(1, 31)), 10'($urandom_range(1, 100))};
			default: c = {10'd30, 10'd12, 10'd60, 10'd20, 5'd4, 10'd40};
		endcase
		return c;
	endfunction

	initial begin
		int ph;
		int s;
		send_idle_pct = 13;
		recv_idle_pct <= 50;
		cur_field_lim = RST_FIELD_LIM;
		bytes_sent = 0;
		bursts_sent = 0;
		settings_done = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: a complete depth sentence with trailing bytes ignored
		sentence.delete();
		load_text("$SDDPT,12.5,0.3*X");
		send_burst(1'b1, 1'b1);
		settle();

		// compact setting so that short directed sentences get past the length check
		program_regs({10'd10, 10'd8, 10'd40, 10'd20, 5'd3, 10'd35});
		// position sentence with the marker after the fields
		sentence.delete();
		load_text("$GPRMC,A,1,B,,,,,,,9*4F");
		send_burst(1'b0, 1'b1);
		// long fields cut, terminator at the limit, '*' closing a field
		sentence.delete();
		load_text("$GPRMC,123,4567,,,,,,*,Q*");
		send_burst(1'b0, 1'b1);
		// last field closed by '*' and no marker after it
		sentence.delete();
		load_text("$GPRMC,1,2,3,4,5,6,7,8,9*");
		send_burst(1'b0, 1'b1);
		// header byte differs
		sentence.delete();
		load_text("$GPRMX,1,2,3");
		send_burst(1'b0, 1'b1);
		// header of the other port
		sentence.delete();
		load_text("$GPRMC,12,3");
		send_burst(1'b1, 1'b1);
		// too short
		sentence.delete();
		load_text("$GP");
		send_burst(1'b0, 1'b1);
		// characters that are skipped
		sentence.delete();
		load_text("$SDDPT,a 1");
		sentence.push_back(8'h00);
		sentence.push_back(8'hFF);
		load_text("2,Z");
		send_burst(1'b1, 1'b1);
		// bytes past the burst limit, with the last mark beyond it
		sentence.delete();
		load_text("$SDDPT,1,2,ABCDEFGHIJKLMNOP");
		send_burst(1'b1, 1'b1);
		// no first mark: continues on the latched port
		sentence.delete();
		load_text("$SDDPT,7,8");
		send_burst(1'b0, 1'b0);
		// single byte burst
		sentence.delete();
		load_text("$");
		send_burst(1'b0, 1'b1);

		// random sentences over the idle patterns and register settings
		for (ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct <= 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct <= 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			for (s = 0; s < 2; s++) begin
				settle();
				program_regs(pick_setting(2 * ph + s));
				setting_bytes = 0;
				while (setting_bytes < BYTES_PER_SETTING)
					random_burst();
			end
		end

		settle();
		repeat (10) @(posedge clk);
		$display("run covered %0d bytes in %0d bursts under %0d register settings",
			bytes_sent, bursts_sent, settings_done + 1);
		$display("idle patterns: sender-heavy, receiver-heavy and none");
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
